[sv/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_INF,
    KIND_LIN,
    KIND_DBL,
    KIND_TWO
  } kind_t;

  localparam int TOL_W = 16;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  localparam int FRONT_STAGES = 5;
  localparam int QUEUE_DEPTH  = 8;
  localparam int QPTR_W       = 3;
  localparam int QCNT_W       = 4;

endpackage

[sv/qrs_front.sv]
// ----------------------------------------------------------------------------
// qrs_front
// Takes coefficient sets, forms the exact discriminant and classifies the case.
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_a,
  input  logic signed [W-1:0] in_b,
  input  logic signed [W-1:0] in_c,
  input  logic [TOL_W-1:0]    tol,
  output logic                out_valid,
  output logic signed [W-1:0] out_a,
  output logic signed [W-1:0] out_b,
  output logic signed [W-1:0] out_c,
  output logic [2*W:0]        out_dmag,
  output kind_t               out_kind
);

  localparam int H  = W / 2;
  localparam int HH = W - H;
  localparam int DW = 2 * W + 1;
  localparam int CW = (DW > TOL_W + F) ? DW : TOL_W + F;

  logic                v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [W-1:0] a1_r, b1_r, c1_r, a2_r, b2_r, c2_r, a3_r, b3_r, c3_r;
  logic signed [W-1:0] a4_r, b4_r, c4_r, a5_r, b5_r, c5_r;
  logic [W-1:0]        ma, mb, mc;
  logic [W+H-1:0]      bblo_r, aclo_r;
  logic [W+HH-1:0]     bbhi_r, achi_r;
  logic                az2_r, bz2_r, cz2_r, acn2_r;
  logic                az3_r, bz3_r, cz3_r, acn3_r;
  logic                az4_r, bz4_r, cz4_r;
  logic [DW-1:0]       bsq3_r, ac43_r;
  logic [DW:0]         dsum4_r, dabs;
  logic [DW-1:0]       dmag5_r;
  kind_t               kind5_r, kind_nxt;
  logic [CW-1:0]       thr, dcmp;

  assign ma = a1_r[W-1] ? (~a1_r + 1'b1) : a1_r;
  assign mb = b1_r[W-1] ? (~b1_r + 1'b1) : b1_r;
  assign mc = c1_r[W-1] ? (~c1_r + 1'b1) : c1_r;

  assign dabs = dsum4_r[DW] ? (~dsum4_r + 1'b1) : dsum4_r;
  assign thr  = CW'({tol, {F{1'b0}}});
  assign dcmp = CW'(dabs[DW-1:0]);

  always_comb begin
    kind_nxt = KIND_NONE;
    if (az4_r) begin
      if (!bz4_r) begin
        kind_nxt = KIND_LIN;
      end else if (cz4_r) begin
        kind_nxt = KIND_INF;
      end
    end else if (dcmp <= thr) begin
      kind_nxt = KIND_DBL;
    end else if (!dsum4_r[DW]) begin
      kind_nxt = KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r <= in_a;
    b1_r <= in_b;
    c1_r <= in_c;

    bblo_r <= mb * mb[H-1:0];
    bbhi_r <= mb * mb[W-1:H];
    aclo_r <= ma * mc[H-1:0];
    achi_r <= ma * mc[W-1:H];
    az2_r  <= ma <= W'(tol);
    bz2_r  <= mb <= W'(tol);
    cz2_r  <= mc <= W'(tol);
    acn2_r <= (a1_r[W-1] != c1_r[W-1]) && (c1_r != '0);
    a2_r   <= a1_r;
    b2_r   <= b1_r;
    c2_r   <= c1_r;

    bsq3_r <= DW'(bblo_r) + (DW'(bbhi_r) << H);
    ac43_r <= (DW'(aclo_r) + (DW'(achi_r) << H)) << 2;
    az3_r  <= az2_r;
    bz3_r  <= bz2_r;
    cz3_r  <= cz2_r;
    acn3_r <= acn2_r;
    a3_r   <= a2_r;
    b3_r   <= b2_r;
    c3_r   <= c2_r;

    dsum4_r <= acn3_r ? ({1'b0, bsq3_r} + {1'b0, ac43_r})
                      : ({1'b0, bsq3_r} - {1'b0, ac43_r});
    az4_r   <= az3_r;
    bz4_r   <= bz3_r;
    cz4_r   <= cz3_r;
    a4_r    <= a3_r;
    b4_r    <= b3_r;
    c4_r    <= c3_r;

    dmag5_r <= dabs[DW-1:0];
    kind5_r <= kind_nxt;
    a5_r    <= a4_r;
    b5_r    <= b4_r;
    c5_r    <= c4_r;
  end

  assign out_valid = v5_r;
  assign out_a     = a5_r;
  assign out_b     = b5_r;
  assign out_c     = c5_r;
  assign out_dmag  = dmag5_r;
  assign out_kind  = kind5_r;

endmodule

[sv/qrs_fifo.sv]
// ----------------------------------------------------------------------------
// qrs_fifo
// Short queue between the classifying front and the solving back.
// ----------------------------------------------------------------------------
module qrs_fifo import qrs_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data,
  output logic [QCNT_W-1:0] count
);

  logic [DATA_W-1:0] mem_r [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              pop;

  assign pop       = cnt_r != '0;
  assign pop_valid = pop;
  assign pop_data  = mem_r[rd_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

[sv/qrs_sqrt.sv]
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic [2*W:0] rad,
  output logic [W:0]   root
);

  localparam int SW = W + 1;
  localparam int RW = 2 * SW;
  localparam int EW = SW + 2;

  logic [EW-1:0] rem_r  [0:SW];
  logic [SW-1:0] root_r [0:SW];
  logic [RW-1:0] rad_r  [0:SW];
  logic [EW-1:0] rem_nxt  [0:SW-1];
  logic [SW-1:0] root_nxt [0:SW-1];
  logic [RW-1:0] rad_nxt  [0:SW-1];

  always_comb begin
    logic [EW+1:0] cand, trial;
    logic          ge;
    for (int s = 0; s < SW; s++) begin
      cand        = {rem_r[s], rad_r[s][RW-1:RW-2]};
      trial       = (EW+2)'({root_r[s], 2'b01});
      ge          = cand >= trial;
      rem_nxt[s]  = ge ? EW'(cand - trial) : EW'(cand);
      root_nxt[s] = {root_r[s][SW-2:0], ge};
      rad_nxt[s]  = rad_r[s] << 2;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    rad_r[0]  <= RW'(rad);
    for (int s = 0; s < SW; s++) begin
      rem_r[s+1]  <= rem_nxt[s];
      root_r[s+1] <= root_nxt[s];
      rad_r[s+1]  <= rad_nxt[s];
    end
  end

  assign root = root_r[SW];

endmodule

[sv/qrs_div.sv]
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined rounding fixed-point divider with saturation, one bit per stage.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic         clk,
  input  logic [W+1:0] n_mag,
  input  logic [W:0]   d_mag,
  input  logic         neg,
  output logic [W-1:0] quot,
  output logic         sat
);

  localparam int NW  = W + F + 4;
  localparam int DDW = W + 2;
  localparam int HW  = NW - W;
  localparam int XW  = (HW > DDW) ? HW : DDW;

  logic [NW-1:0]  num;
  logic [DDW-1:0] dd;
  logic [XW-1:0]  hi;
  logic [DDW-1:0] rem_r [0:W];
  logic [W-1:0]   lo_r  [0:W];
  logic [W-1:0]   q_r   [0:W];
  logic [DDW-1:0] dd_r  [0:W];
  logic           ovf_r [0:W];
  logic           neg_r [0:W];
  logic [DDW-1:0] rem_nxt [0:W-1];
  logic [W-1:0]   q_nxt   [0:W-1];
  logic [W-1:0]   limit, qs;

  assign num = (NW'(n_mag) << (F + 1)) + NW'(d_mag);
  assign dd  = {d_mag, 1'b0};
  assign hi  = XW'(num[NW-1:W]);

  always_comb begin
    logic [DDW:0] cand;
    logic         ge;
    for (int j = 0; j < W; j++) begin
      cand       = {rem_r[j], lo_r[j][W-1]};
      ge         = cand >= {1'b0, dd_r[j]};
      rem_nxt[j] = ge ? DDW'(cand - {1'b0, dd_r[j]}) : DDW'(cand);
      q_nxt[j]   = {q_r[j][W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= hi[DDW-1:0];
    lo_r[0]  <= num[W-1:0];
    q_r[0]   <= '0;
    dd_r[0]  <= dd;
    ovf_r[0] <= hi >= XW'(dd);
    neg_r[0] <= neg;
    for (int j = 0; j < W; j++) begin
      rem_r[j+1] <= rem_nxt[j];
      lo_r[j+1]  <= lo_r[j] << 1;
      q_r[j+1]   <= q_nxt[j];
      dd_r[j+1]  <= dd_r[j];
      ovf_r[j+1] <= ovf_r[j];
      neg_r[j+1] <= neg_r[j];
    end
  end

  assign limit = neg_r[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign sat   = ovf_r[W] || (q_r[W] > limit);
  assign qs    = sat ? limit : q_r[W];
  assign quot  = neg_r[W] ? (~qs + 1'b1) : qs;

endmodule

[sv/qrs_back.sv]
// ----------------------------------------------------------------------------
// qrs_back
// Takes classified transactions, runs the square root and both divisions.
// ----------------------------------------------------------------------------
module qrs_back import qrs_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_a,
  input  logic signed [W-1:0] in_b,
  input  logic signed [W-1:0] in_c,
  input  logic [2*W:0]        in_dmag,
  input  kind_t               in_kind,
  output logic                out_valid,
  output logic [1:0]          out_count,
  output logic [W-1:0]        out_first,
  output logic [W-1:0]        out_second,
  output logic                out_sat
);

  localparam int SQL = W + 2;
  localparam int DL  = W + 1;

  logic                sv_r [0:SQL-1];
  kind_t               sk_r [0:SQL-1];
  logic signed [W-1:0] sa_r [0:SQL-1];
  logic signed [W-1:0] sb_r [0:SQL-1];
  logic signed [W-1:0] sc_r [0:SQL-1];
  logic [W:0]          sroot;

  logic                vp_r;
  kind_t               kp_r;
  logic signed [W+1:0] n1_r, n2_r, nb, nc, sx;
  logic signed [W:0]   m_r;

  logic [W+1:0]        n1mag, n2mag;
  logic [W:0]          mmag;
  logic                neg1, neg2;

  logic                dv_r [0:DL-1];
  kind_t               dk_r [0:DL-1];
  logic [W-1:0]        q1, q2;
  logic                sat1, sat2;

  logic                ov_r, osat_r;
  logic [1:0]          ocnt_r;
  logic [W-1:0]        or1_r, or2_r;

  qrs_sqrt #(.W(W)) u_sqrt (
    .clk  (clk),
    .rad  (in_dmag),
    .root (sroot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQL; i++) begin
        sv_r[i] <= 1'b0;
      end
    end else begin
      sv_r[0] <= in_valid;
      for (int i = 1; i < SQL; i++) begin
        sv_r[i] <= sv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    sk_r[0] <= in_kind;
    sa_r[0] <= in_a;
    sb_r[0] <= in_b;
    sc_r[0] <= in_c;
    for (int i = 1; i < SQL; i++) begin
      sk_r[i] <= sk_r[i-1];
      sa_r[i] <= sa_r[i-1];
      sb_r[i] <= sb_r[i-1];
      sc_r[i] <= sc_r[i-1];
    end
  end

  assign nb = -(W+2)'(sb_r[SQL-1]);
  assign nc = -(W+2)'(sc_r[SQL-1]);
  assign sx = $signed({1'b0, sroot});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else begin
      vp_r <= sv_r[SQL-1];
    end
  end

  always_ff @(posedge clk) begin
    kp_r <= sk_r[SQL-1];
    if (sk_r[SQL-1] == KIND_LIN) begin
      n1_r <= nc;
      m_r  <= (W+1)'(sb_r[SQL-1]);
    end else begin
      n1_r <= (sk_r[SQL-1] == KIND_TWO) ? (nb - sx) : nb;
      m_r  <= {sa_r[SQL-1], 1'b0};
    end
    n2_r <= nb + sx;
  end

  assign n1mag = n1_r[W+1] ? (~n1_r + 1'b1) : n1_r;
  assign n2mag = n2_r[W+1] ? (~n2_r + 1'b1) : n2_r;
  assign mmag  = m_r[W] ? (~m_r + 1'b1) : m_r;
  assign neg1  = (n1_r[W+1] != m_r[W]) && (n1_r != '0);
  assign neg2  = (n2_r[W+1] != m_r[W]) && (n2_r != '0);

  qrs_div #(.W(W), .F(F)) u_div_first (
    .clk   (clk),
    .n_mag (n1mag),
    .d_mag (mmag),
    .neg   (neg1),
    .quot  (q1),
    .sat   (sat1)
  );

  qrs_div #(.W(W), .F(F)) u_div_second (
    .clk   (clk),
    .n_mag (n2mag),
    .d_mag (mmag),
    .neg   (neg2),
    .quot  (q2),
    .sat   (sat2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else begin
      dv_r[0] <= vp_r;
      for (int i = 1; i < DL; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dk_r[0] <= kp_r;
    for (int i = 1; i < DL; i++) begin
      dk_r[i] <= dk_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= dv_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    unique case (dk_r[DL-1]) inside
      KIND_LIN, KIND_DBL: begin
        ocnt_r <= CNT_ONE;
        or1_r  <= q1;
        or2_r  <= q1;
        osat_r <= sat1;
      end
      KIND_TWO: begin
        ocnt_r <= CNT_TWO;
        or1_r  <= q1;
        or2_r  <= q2;
        osat_r <= sat1 | sat2;
      end
      KIND_INF: begin
        ocnt_r <= CNT_INF;
        or1_r  <= '0;
        or2_r  <= '0;
        osat_r <= 1'b0;
      end
      default: begin
        ocnt_r <= CNT_NONE;
        or1_r  <= '0;
        or2_r  <= '0;
        osat_r <= 1'b0;
      end
    endcase
  end

  assign out_valid  = ov_r;
  assign out_count  = ocnt_r;
  assign out_first  = or1_r;
  assign out_second = or2_r;
  assign out_sat    = osat_r;

endmodule

[sv/quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+--------------------------------------
//  input    | start & !busy              | in_coeff_a, in_coeff_b, in_coeff_c
//  result   | out_valid, one cycle       | out_root_count, out_root_first,
//           |                            | out_root_second, out_saturated
//  config   | cfg_valid & cfg_ready      | cfg_data (zero tolerance)
//
// One transaction can be taken every cycle while busy is low; each result
// reaches the ports after passing the front, the queue, the bit-per-stage
// square root and the dividers.
// Reset clears all pipeline valids and loads a zero tolerance of one.
// The result side cannot stall, so busy rises only if the queue would overflow.
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] in_coeff_a,
  input  logic signed [WORD_BITS-1:0] in_coeff_b,
  input  logic signed [WORD_BITS-1:0] in_coeff_c,
  output logic                        out_valid,
  output logic [1:0]                  out_root_count,
  output logic signed [WORD_BITS-1:0] out_root_first,
  output logic signed [WORD_BITS-1:0] out_root_second,
  output logic                        out_saturated,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [TOL_W-1:0]            cfg_data
);

  localparam int W  = WORD_BITS;
  localparam int DW = 2 * W + 1;
  localparam int QW = 3 * W + DW + 3;

  logic [TOL_W-1:0]    tol_r;
  logic                acc;
  logic                fv;
  logic signed [W-1:0] fa, fb, fc;
  logic [DW-1:0]       fd;
  kind_t               fk;
  logic                qv;
  logic [QW-1:0]       qdata;
  logic [QCNT_W-1:0]   qcnt;
  logic [W-1:0]        r1, r2;

  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;
  assign busy      = qcnt >= QCNT_W'(QUEUE_DEPTH - FRONT_STAGES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  qrs_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc),
    .in_a      (in_coeff_a),
    .in_b      (in_coeff_b),
    .in_c      (in_coeff_c),
    .tol       (tol_r),
    .out_valid (fv),
    .out_a     (fa),
    .out_b     (fb),
    .out_c     (fc),
    .out_dmag  (fd),
    .out_kind  (fk)
  );

  qrs_fifo #(.DATA_W(QW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fv),
    .push_data ({fa, fb, fc, fd, fk}),
    .pop_valid (qv),
    .pop_data  (qdata),
    .count     (qcnt)
  );

  qrs_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (qv),
    .in_a       (qdata[QW-1 -: W]),
    .in_b       (qdata[QW-W-1 -: W]),
    .in_c       (qdata[QW-2*W-1 -: W]),
    .in_dmag    (qdata[DW+2:3]),
    .in_kind    (kind_t'(qdata[2:0])),
    .out_valid  (out_valid),
    .out_count  (out_root_count),
    .out_first  (r1),
    .out_second (r2),
    .out_sat    (out_saturated)
  );

  assign out_root_first  = r1;
  assign out_root_second = r2;

endmodule

[sim/tb_quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver
// Self-checking testbench of the fixed-point quadratic root solver.
// Coefficient sets are sent as start/busy transactions with random gaps.
// Each one is solved by a predictor in the testbench, and every strobed
// result is checked against the oldest solution that is still waiting.
// Directed sets cover the field extremes and every root case. Random sets
// mix full-range values, exact double and two-root equations, linear
// equations and coefficients near the zero tolerance. Several tolerance
// settings are used, including both extremes.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam int W = 32;
  localparam int FB = 16;
  localparam int LATENCY = 2 * W + 11;

  typedef struct {
    logic [1:0]   count;
    logic [W-1:0] first;
    logic [W-1:0] second;
    logic         sat;
  } roots_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic signed [W-1:0] in_coeff_a = '0;
  logic signed [W-1:0] in_coeff_b = '0;
  logic signed [W-1:0] in_coeff_c = '0;
  logic                out_valid;
  logic [1:0]          out_root_count;
  logic signed [W-1:0] out_root_first;
  logic signed [W-1:0] out_root_second;
  logic                out_saturated;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TOL_W-1:0]    cfg_data = '0;

  roots_t           pending_roots[$];
  logic [TOL_W-1:0] tolerance = 16'd1;
  int               errors = 0;
  int               sent = 0;
  int               received = 0;
  int               count_seen[4] = '{0, 0, 0, 0};
  int               sat_seen = 0;
  bit               no_idle = 1'b0;

  quadratic_root_solver #(.FRAC_BITS(FB), .WORD_BITS(W)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coeff_a(in_coeff_a), .in_coeff_b(in_coeff_b), .in_coeff_c(in_coeff_c),
    .out_valid(out_valid), .out_root_count(out_root_count),
    .out_root_first(out_root_first), .out_root_second(out_root_second),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] d);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int k = 40; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if ({64'd0, c} * {64'd0, c} <= d) r = c;
    end
    return r;
  endfunction

  function automatic logic [W-1:0] scaled_quotient(longint n, longint m, ref logic sat);
    logic [127:0] dm;
    logic [127:0] q;
    logic [63:0]  limit;
    bit           neg;
    if (m == 0) return '0;
    dm = magnitude(m);
    q = ((({64'd0, magnitude(n)}) << (FB + 1)) + dm) / (dm << 1);
    neg = ((n < 0) != (m < 0)) && n != 0;
    limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q > limit) begin
      q = limit;
      sat = 1'b1;
    end
    return neg ? -q[W-1:0] : q[W-1:0];
  endfunction

  function automatic roots_t solve_quadratic(logic signed [W-1:0] a, logic signed [W-1:0] b,
                                             logic signed [W-1:0] c, logic [TOL_W-1:0] tol);
    roots_t       r;
    longint       sa;
    longint       sb;
    longint       sc;
    longint       s;
    logic [127:0] b2;
    logic [127:0] ac4;
    logic [127:0] dmag;
    logic [127:0] thr;
    bit           ac_neg;
    bit           dneg;
    sa = a;
    sb = b;
    sc = c;
    r = '{CNT_NONE, '0, '0, 1'b0};
    if (magnitude(sa) <= tol) begin
      if (magnitude(sb) > tol) begin
        r.first = scaled_quotient(-sc, sb, r.sat);
        r.second = r.first;
        r.count = CNT_ONE;
      end else begin
        r.count = magnitude(sc) > tol ? CNT_NONE : CNT_INF;
      end
    end else begin
      b2 = {64'd0, magnitude(sb)} * {64'd0, magnitude(sb)};
      ac4 = ({64'd0, magnitude(sa)} * {64'd0, magnitude(sc)}) << 2;
      ac_neg = ((sa < 0) != (sc < 0)) && sc != 0;
      dneg = 1'b0;
      thr = {112'd0, tol} << FB;
      if (ac_neg) dmag = b2 + ac4;
      else if (b2 >= ac4) dmag = b2 - ac4;
      else begin
        dmag = ac4 - b2;
        dneg = 1'b1;
      end
      if (dmag <= thr) begin
        r.first = scaled_quotient(-sb, 2 * sa, r.sat);
        r.second = r.first;
        r.count = CNT_ONE;
      end else if (!dneg) begin
        s = floor_sqrt(dmag);
        r.first = scaled_quotient(-sb - s, 2 * sa, r.sat);
        r.second = scaled_quotient(-sb + s, 2 * sa, r.sat);
        r.count = CNT_TWO;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR at result %0d: %s got %h expected %h", received, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    roots_t want;
    if (rst_n && out_valid) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected result strobe", 64'd1, 64'd0);
      end else begin
        want = pending_roots.pop_front();
        if (out_root_count !== want.count) report_mismatch("root_count", out_root_count, want.count);
        if (out_root_first !== want.first) report_mismatch("root_first", out_root_first, want.first);
        if (out_root_second !== want.second)
          report_mismatch("root_second", out_root_second, want.second);
        if (out_saturated !== want.sat) report_mismatch("saturated", out_saturated, want.sat);
        count_seen[want.count]++;
        if (want.sat) sat_seen++;
      end
      received++;
    end
  end

  task automatic send_coeffs(logic signed [W-1:0] a, logic signed [W-1:0] b,
                             logic signed [W-1:0] c);
    start <= 1'b1;
    in_coeff_a <= a;
    in_coeff_b <= b;
    in_coeff_c <= c;
    do @(posedge clk); while (busy);
    pending_roots.push_back(solve_quadratic(a, b, c, tolerance));
    sent++;
    if (!no_idle && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tolerance = value;
  endtask

  function automatic int small_signed(int range);
    return int'($urandom_range(0, 2 * range)) - range;
  endfunction

  task automatic send_random_set();
    int ai;
    int p;
    int q;
    int t;
    t = tolerance;
    ai = small_signed(8);
    if (ai == 0) ai = 1;
    p = small_signed(12);
    q = small_signed(12);
    case ($urandom_range(0, 7))
      0: send_coeffs($urandom, $urandom, $urandom);
      1: send_coeffs(small_signed(1 << 20), small_signed(1 << 20), small_signed(1 << 20));
      2: send_coeffs(ai << FB, (-2 * ai * p) << FB, (ai * p * p) << FB);
      3, 4: send_coeffs(ai << FB, (-ai * (p + q)) << FB, (ai * p * q) << FB);
      5: send_coeffs(small_signed(t + 1), $urandom, small_signed(1 << 24));
      6: send_coeffs(small_signed(t + 2), small_signed(t + 2), small_signed(t + 2));
      default: send_coeffs(small_signed(4), $urandom, $urandom);
    endcase
  endtask

  task automatic test_directed();
    send_coeffs(0, 0, 0);
    send_coeffs(0, 0, 32'sh0001_0000);
    send_coeffs(0, 32'sh0002_0000, 32'sh0001_0000);
    send_coeffs(1, -1, 1);
    send_coeffs(0, 32'sh0000_0002, 32'sh7FFF_FFFF);
    send_coeffs(0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_coeffs(32'sh0001_0000, 32'shFFFE_0000, 32'sh0001_0000);
    send_coeffs(32'sh0001_0000, 0, 32'sh0001_0000);
    send_coeffs(32'sh0001_0000, 0, 32'shFFFC_0000);
    send_coeffs(32'shFFFF_0000, 0, 32'sh0004_0000);
    send_coeffs(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_coeffs(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_coeffs(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_coeffs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    send_coeffs(2, 32'sh7FFF_FFFF, 0);
    send_coeffs(2, 32'sh8000_0000, 32'sh8000_0000);
    send_coeffs(-2, 32'sh0100_0000, 32'sh7FFF_FFFF);
    send_coeffs(32'sh0003_0000, 32'sh0001_0000, 32'shFFFF_0000);
    send_coeffs(32'sh0000_0003, 32'sh0000_0001, 32'sh0000_0005);
    send_coeffs(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
  endtask

  task automatic test_tolerance_extremes();
    write_tolerance(16'd0);
    send_coeffs(0, 0, 0);
    send_coeffs(1, 0, 0);
    send_coeffs(0, 1, 32'sh0001_0000);
    send_coeffs(0, 0, 1);
    repeat (40) send_random_set();
    write_tolerance(16'hFFFF);
    send_coeffs(32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh0000_FFFF);
    send_coeffs(32'sh0001_0000, 32'sh0000_FFFF, 32'sh0001_0000);
    send_coeffs(32'shFFFF_0001, 32'sh0001_0000, 0);
    repeat (40) send_random_set();
  endtask

  task automatic test_drain_pause();
    repeat (30) send_random_set();
    drain_results();
    @(posedge clk);
    repeat (30) send_random_set();
  endtask

  task automatic test_random_sets();
    for (int i = 0; i < 480; i++) begin
      if (i % 160 == 0) write_tolerance(16'($urandom_range(0, 300)));
      no_idle = (i >= 250 && i < 400);
      send_random_set();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_tolerance_extremes();
    write_tolerance(16'd1);
    test_drain_pause();
    test_random_sets();
    drain_results();
    $display("Checked %0d of %0d coefficient sets over several tolerances: %0d none, %0d one,",
             received, sent, count_seen[0], count_seen[1]);
    $display("%0d two and %0d infinite root results, %0d of them saturated.",
             count_seen[2], count_seen[3], sat_seen);
    if (errors == 0 && received == sent) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending", pending_roots.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
